[src/ghu_pkg.sv]
package ghu_pkg;

  // Histogram geometry.
  localparam int unsigned Bins       = 256;
  localparam int unsigned BinAw      = $clog2(Bins);
  localparam int unsigned CountWidth = 32;
  localparam int unsigned OutWidth   = 32;
  localparam int unsigned PixWidth   = 8;

  // Gray weighting: (r*11 + g*16 + b*5) >> 5.
  localparam int unsigned WeightR   = 11;
  localparam int unsigned WeightG   = 16;
  localparam int unsigned WeightB   = 5;
  localparam int unsigned GrayShift = 5;
  localparam int unsigned SumWidth  = PixWidth + GrayShift;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [BinAw-1:0]      bin_addr_t;
  typedef logic [OutWidth-1:0]   out_count_t;

  localparam count_t     CountMax = {CountWidth{1'b1}};
  localparam out_count_t OutMax   = {OutWidth{1'b1}};

  // Operation codes carried by a transaction.
  typedef enum logic [1:0] {
    OpAccum     = 2'd0,
    OpRead      = 2'd1,
    OpReadClear = 2'd2,
    OpUnused    = 2'd3
  } opcode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // Latch the bin address of an accepted transaction.
    logic use_gray;  // Address comes from the pixel, not from bin_index.
    logic rd_en;     // Read the addressed bin into the read register.
    logic wr_en;     // Write back the incremented count.
    logic clear;     // Mark the addressed bin as zero.
    logic emit;      // Present the read count as a result.
  } ghu_cmd_t;

  // Gray level of one pixel.
  function automatic bin_addr_t gray_level(logic [PixWidth-1:0] r,
                                           logic [PixWidth-1:0] g,
                                           logic [PixWidth-1:0] b);
    logic [SumWidth-1:0] sum;
    sum = SumWidth'(r) * SumWidth'(WeightR)
        + SumWidth'(g) * SumWidth'(WeightG)
        + SumWidth'(b) * SumWidth'(WeightB);
    return BinAw'(sum >> GrayShift);
  endfunction

endpackage

[src/ghu_ctrl.sv]
module ghu_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       opcode_i,
  output logic             busy,
  output ghu_pkg::ghu_cmd_t cmd_o
);
  import ghu_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StRead   = 3'b010,
    StUpdate = 3'b100
  } state_e;

  state_e  state_q, state_d;
  opcode_e op_q, op_d;
  logic    accept;

  assign busy   = (state_q != StIdle);
  assign accept = start && (state_q == StIdle);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          op_d           = opcode_e'(opcode_i);
          cmd_o.capture  = 1'b1;
          cmd_o.use_gray = (opcode_e'(opcode_i) == OpAccum);
          if (opcode_e'(opcode_i) != OpUnused) begin
            state_d = StRead;
          end
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StUpdate;
      end
      StUpdate: begin
        cmd_o.wr_en = (op_q == OpAccum);
        cmd_o.clear = (op_q == OpReadClear);
        cmd_o.emit  = (op_q == OpRead) || (op_q == OpReadClear);
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and latched operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= OpAccum;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

[src/ghu_datapath.sv]
module ghu_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ghu_pkg::ghu_cmd_t        cmd_i,
  input  logic [7:0]               red_i,
  input  logic [7:0]               green_i,
  input  logic [7:0]               blue_i,
  input  logic [7:0]               bin_index_i,
  output logic [31:0]              bin_count_o,
  output logic                     done_o
);
  import ghu_pkg::*;

  bin_addr_t  addr_q;
  count_t     mem [Bins];
  count_t     rdata_q;
  logic       vld_rd_q;
  logic [Bins-1:0] valid_q;
  count_t     count;
  count_t     incr;
  logic [63:0] count_wide;
  out_count_t out_d;
  out_count_t bin_count_q;
  logic       done_q;

  // Bin address of the accepted transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= cmd_i.use_gray ? gray_level(red_i, green_i, blue_i)
                               : BinAw'(bin_index_i);
    end
  end

  // Count store with registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[addr_q];
    end
    if (cmd_i.wr_en) begin
      mem[addr_q] <= incr;
    end
  end

  // Per-bin valid flags; a bin that is not valid reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        vld_rd_q <= valid_q[addr_q];
      end
      if (cmd_i.wr_en) begin
        valid_q[addr_q] <= 1'b1;
      end else if (cmd_i.clear) begin
        valid_q[addr_q] <= 1'b0;
      end
    end
  end

  // Saturating increment and result clamp.
  assign count      = vld_rd_q ? rdata_q : '0;
  assign incr       = (count == CountMax) ? count : count + count_t'(1);
  assign count_wide = 64'(count);
  assign out_d      = (count_wide > 64'(OutMax)) ? OutMax : count_wide[OutWidth-1:0];

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      bin_count_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  assign bin_count_o = bin_count_q;
  assign done_o      = done_q;

endmodule

[src/grayscale_histogram_unit.sv]
// Channel   | Direction | Ports                                         | Handshake
// ----------+-----------+-----------------------------------------------+--------------------
// command   | in        | opcode_i, red_i, green_i, blue_i, bin_index_i | start high, busy low
// result    | out       | bin_count_o                                   | done_o, one cycle
//
// A transaction passes through the accept, a read of the count store,
// and an update step that writes back or clears the bin or emits the count. The
// count store is read before it is written; an unused opcode is dropped at acceptance.
// Reads show their result in the cycle after the update, while the next transaction
// may already be accepted. Reset clears all bins at once through per-bin valid
// flags. The receiver cannot stall; each result stands for exactly one cycle.
module grayscale_histogram_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  bin_index_i,
  output logic [31:0] bin_count_o,
  output logic        done_o
);
  import ghu_pkg::*;

  ghu_cmd_t cmd;

  // Sequencer for each transaction.
  ghu_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // Count store and result path.
  ghu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .bin_index_i (bin_index_i),
    .bin_count_o (bin_count_o),
    .done_o      (done_o)
  );

endmodule

[src/ghu_checker.sv]
module ghu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode_i,
  input logic        done_o
);
  import ghu_pkg::*;

  logic accept;
  logic is_read;

  assign accept  = start && !busy;
  assign is_read = (opcode_i == OpRead) || (opcode_i == OpReadClear);

  // A read transaction gives its result once it has passed the read and update states.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_read |-> ##3 done_o)
    else $error("read transaction produced no result");

  // An accumulate transaction never gives a result.
  a_accum_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (opcode_i == OpAccum) |-> ##3 !done_o)
    else $error("accumulate transaction produced a result");

  // A result is never followed directly by another result.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("results on consecutive cycles");

  // The unit is free again when a result is shown.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy while a result is shown");

  // An unused opcode is dropped at acceptance and never makes the unit busy.
  a_unused_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (opcode_i == OpUnused) |=> !busy)
    else $error("unused opcode kept the unit busy");

endmodule

bind grayscale_histogram_unit ghu_checker u_ghu_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .opcode_i (opcode_i),
  .done_o   (done_o)
);

[sim/tb_grayscale_histogram_unit.sv]
module tb_grayscale_histogram_unit;
  import ghu_pkg::*;

  // Cycles without any accepted transaction or result before the run is abandoned.
  localparam int unsigned StallLimit = 1000;
  // Cycles allowed for the block to settle after the last result.
  localparam int unsigned TailCycles = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  opcode_e     opcode_i;
  logic [7:0]  red_i;
  logic [7:0]  green_i;
  logic [7:0]  blue_i;
  logic [7:0]  bin_index_i;
  logic [31:0] bin_count_o;
  logic        done_o;

  // Predicted histogram and the bin counts that reads are expected to return.
  count_t      hist_counts [Bins];
  out_count_t  expected_counts [$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  // Recently hit gray levels, so that reads often find nonzero bins.
  bin_addr_t   recent_levels [8];

  grayscale_histogram_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .bin_index_i (bin_index_i),
    .bin_count_o (bin_count_o),
    .done_o      (done_o)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Weighted luminance of one pixel, worked out independently of the block.
  function automatic bin_addr_t luma_level(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned weighted;
    weighted = 11 * int'(r) + 16 * int'(g) + 5 * int'(b);
    return bin_addr_t'(weighted >> 5);
  endfunction

  // Applies one accepted transaction to the predicted histogram.
  task automatic update_histogram(opcode_e op, logic [7:0] r, logic [7:0] g,
                                  logic [7:0] b, logic [7:0] idx);
    bin_addr_t level;
    case (op)
      OpAccum: begin
        level = luma_level(r, g, b);
        // Counters hold at their maximum rather than wrapping.
        if (hist_counts[level] != CountMax) begin
          hist_counts[level] = hist_counts[level] + 1'b1;
        end
        recent_levels[$urandom_range(7)] = level;
      end
      OpRead: begin
        expected_counts.push_back(out_count_t'(hist_counts[idx]));
      end
      OpReadClear: begin
        expected_counts.push_back(out_count_t'(hist_counts[idx]));
        hist_counts[idx] = '0;
      end
      default: begin
        // The unused opcode leaves the histogram untouched.
      end
    endcase
  endtask

  // Presents one transaction and holds it until the block accepts it.
  // Called at a rising edge; returns at the edge of acceptance with start still high.
  task automatic issue_command(opcode_e op, logic [7:0] r, logic [7:0] g,
                               logic [7:0] b, logic [7:0] idx);
    start       <= 1'b1;
    opcode_i    <= op;
    red_i       <= r;
    green_i     <= g;
    blue_i      <= b;
    bin_index_i <= idx;
    do begin
      @(posedge clk_i);
    end while (busy);
    update_histogram(op, r, g, b, idx);
  endtask

  // Lets the sender go idle for a random number of cycles.
  task automatic idle_sender(int unsigned max_cycles);
    start <= 1'b0;
    repeat ($urandom_range(max_cycles, 1)) @(posedge clk_i);
  endtask

  // Holds the sender off until every pending read has returned.
  // At least one edge passes, so start is never driven twice in one step.
  task automatic wait_results_drained();
    start <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (expected_counts.size() != 0);
  endtask

  // Reads from a freshly reset histogram must all return zero.
  task automatic test_empty_histogram();
    issue_command(OpRead, 8'h00, 8'h00, 8'h00, 8'h00);
    issue_command(OpRead, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue_command(OpReadClear, 8'h00, 8'h00, 8'h00, 8'h80);
    wait_results_drained();
  endtask

  // Black, white and each pure primary, with reads right behind the updates.
  task automatic test_pixel_extremes();
    issue_command(OpAccum, 8'h00, 8'h00, 8'h00, 8'hFF);
    issue_command(OpAccum, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    issue_command(OpAccum, 8'hFF, 8'h00, 8'h00, 8'hAA);
    issue_command(OpAccum, 8'h00, 8'hFF, 8'h00, 8'h55);
    issue_command(OpAccum, 8'h00, 8'h00, 8'hFF, 8'hFF);
    issue_command(OpRead, 8'h00, 8'h00, 8'h00, 8'h00);
    issue_command(OpRead, 8'h00, 8'h00, 8'h00, 8'hFF);
    wait_results_drained();
  endtask

  // The unused opcode must neither change a bin nor produce a result.
  task automatic test_unused_opcode();
    issue_command(OpUnused, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue_command(OpRead, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    wait_results_drained();
  endtask

  // Read-and-clear returns the old count and leaves the bin at zero.
  task automatic test_read_and_clear();
    issue_command(OpAccum, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    issue_command(OpReadClear, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue_command(OpRead, 8'h00, 8'h00, 8'h00, 8'hFF);
    issue_command(OpRead, 8'hFF, 8'hFF, 8'hFF, 8'd87);
    wait_results_drained();
  endtask

  // Image-like traffic: runs of similar pixels, reads of hot bins, some noise.
  task automatic test_random_traffic(int unsigned idle_pct, int unsigned n_items);
    opcode_e     op;
    logic [7:0]  r, g, b, idx;
    logic [7:0]  base_r, base_g, base_b;
    int unsigned roll;
    base_r = 8'($urandom);
    base_g = 8'($urandom);
    base_b = 8'($urandom);
    for (int unsigned i = 0; i < n_items; i++) begin
      // A new dominant color now and then, as when the scene changes.
      if ($urandom_range(63) == 0) begin
        base_r = 8'($urandom);
        base_g = 8'($urandom);
        base_b = 8'($urandom);
      end
      r    = 8'($urandom);
      g    = 8'($urandom);
      b    = 8'($urandom);
      idx  = 8'($urandom);
      roll = $urandom_range(99);
      if (roll < 68) begin
        op = OpAccum;
        if ($urandom_range(1) == 0) begin
          r = base_r ^ 8'($urandom_range(3));
          g = base_g ^ 8'($urandom_range(1));
          b = base_b ^ 8'($urandom_range(7));
        end
      end else if (roll < 95) begin
        op = ($urandom_range(2) == 0) ? OpReadClear : OpRead;
        if ($urandom_range(1) == 0) begin
          idx = recent_levels[$urandom_range(7)];
        end
      end else begin
        op = OpUnused;
      end
      issue_command(op, r, g, b, idx);
      if ($urandom_range(99) < idle_pct) begin
        idle_sender(6);
      end
    end
    wait_results_drained();
  endtask

  // Compares each result transaction with the oldest expected count.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual bin_count %0d",
                 $time, bin_count_o);
        mismatch_count++;
      end else begin
        out_count_t want;
        want = expected_counts.pop_front();
        if (bin_count_o !== want) begin
          $display("%0t: bin_count mismatch, expected %0d, actual %0d",
                   $time, want, bin_count_o);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_grayscale_histogram_unit: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset, then the directed tests, then random traffic under several idle settings.
  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    opcode_i       <= OpAccum;
    red_i          <= '0;
    green_i        <= '0;
    blue_i         <= '0;
    bin_index_i    <= '0;
    mismatch_count = 0;
    for (int i = 0; i < Bins; i++) begin
      hist_counts[i] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      recent_levels[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_histogram();
    test_pixel_extremes();
    test_unused_opcode();
    test_read_and_clear();
    test_random_traffic(0, 390);
    test_random_traffic(48, 385);
    test_random_traffic(0, 385);
    test_random_traffic(30, 385);

    // Give the block time to finish any trailing update.
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_counts.size() == 0) begin
      $display("tb_grayscale_histogram_unit: PASS");
    end else begin
      $display("tb_grayscale_histogram_unit: FAIL");
    end
    $finish;
  end

endmodule
